[sv/bitmap_first_fit_allocator_macros.svh]
// assertion macros for the bitmap first-fit allocator
// no dependencies; included by the top level
`ifndef BITMAP_FIRST_FIT_ALLOCATOR_MACROS_SVH
`define BITMAP_FIRST_FIT_ALLOCATOR_MACROS_SVH

// checked on every rising clock edge outside reset
`define BFFA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every rising clock edge, reset included
`define BFFA_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

[sv/bffa_pkg.sv]
// constants and codes for the bitmap first-fit allocator
// no dependencies
package bffa_pkg;

   localparam int MAP_BITS  = 1024;
   localparam int WORD_BITS = 8;
   localparam int WORDS     = MAP_BITS / WORD_BITS;
   localparam int IDX_W     = $clog2(MAP_BITS);
   localparam int WADDR_W   = $clog2(WORDS);
   localparam int BIT_W     = $clog2(WORD_BITS);
   localparam int LEN_W     = IDX_W + 1;
   localparam int GRAN_W    = 21;
   localparam int SIZE_W    = 32;
   localparam int ADDR_W    = 64;
   localparam int DIV_CNT_W = $clog2(ADDR_W);
   localparam int CSR_IDX_W = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_POOL_ENABLED  = 2'd0,
      CSR_POOL_BYTES    = 2'd1,
      CSR_BYTES_PER_BIT = 2'd2,
      CSR_POOL_BASE     = 2'd3
   } csr_index_type;

   typedef enum logic {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } cmd_type;

   typedef enum logic {
      STATUS_POOL = 1'b0,
      STATUS_HEAP = 1'b1
   } status_type;

endpackage

[sv/bffa_if.sv]
// request, response and register-write channels of the allocator
// depends on bffa_pkg
interface bffa_req_if;
   logic                           valid;
   logic                           ready;
   logic                           cmd;
   logic [bffa_pkg::SIZE_W-1:0]    req_size;
   logic [bffa_pkg::ADDR_W-1:0]    free_addr;
   modport source (output valid, cmd, req_size, free_addr, input ready);
   modport sink (input valid, cmd, req_size, free_addr, output ready);
endinterface

interface bffa_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           status;
   logic [bffa_pkg::ADDR_W-1:0]    result_addr;
   logic [bffa_pkg::LEN_W-1:0]     run_bits;
   modport source (output valid, status, result_addr, run_bits, input ready);
   modport sink (input valid, status, result_addr, run_bits, output ready);
endinterface

interface bffa_csr_if;
   logic                           valid;
   logic                           ready;
   logic [bffa_pkg::CSR_IDX_W-1:0] index;
   logic [bffa_pkg::ADDR_W-1:0]    data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[sv/bitmap_first_fit_allocator.sv]
// Allocate: divide, scan the byte-wide bitmap RAM byte by byte for the first fit, then
// read and write each byte of the run. Free: divide, read the run length, clear its bytes.
// Requests refused before the divide skip it; the divider is 64-step, shared and restoring.
// One request is in flight at a time; a finished response waits in its output register.
// Reset (synchronous, active high) loads register defaults, then a clearing pass zeroes
// both memories; register writes are taken during the pass, requests are not.
`include "bitmap_first_fit_allocator_macros.svh"

module bitmap_first_fit_allocator (
   input  logic        clock,
   input  logic        reset,
   bffa_req_if.sink    req_bus,
   bffa_rsp_if.source  rsp_bus,
   bffa_csr_if.sink    csr_bus
);

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_DIV, ST_POST, ST_TREAD, ST_SCAN, ST_FILL_RD, ST_FILL_WR
   } state_type;

   state_type state_ff;
   logic      done_ff;

   logic                          en_ff;
   logic [bffa_pkg::SIZE_W-1:0]   pool_bytes_ff;
   logic [bffa_pkg::GRAN_W-1:0]   bpb_ff;
   logic [bffa_pkg::ADDR_W-1:0]   base_ff;

   logic                          cmd_ff;
   logic [bffa_pkg::IDX_W-1:0]    clr_ff;
   logic [bffa_pkg::GRAN_W-1:0]   rem_ff;
   logic [bffa_pkg::ADDR_W-1:0]   dq_ff;
   logic [bffa_pkg::DIV_CNT_W-1:0] div_cnt_ff;
   logic [bffa_pkg::LEN_W-1:0]    nbits_ff;
   logic [bffa_pkg::LEN_W-1:0]    need_ff;
   logic [bffa_pkg::LEN_W-1:0]    zeros_ff;
   logic [bffa_pkg::WADDR_W-1:0]  scan_w_ff;
   logic [bffa_pkg::IDX_W-1:0]    idx_ff;
   logic [bffa_pkg::LEN_W-1:0]    lo_ff;
   logic [bffa_pkg::LEN_W-1:0]    hi_ff;
   logic [bffa_pkg::WADDR_W-1:0]  fill_w_ff;
   logic                          fill_set_ff;
   logic [bffa_pkg::IDX_W+bffa_pkg::GRAN_W-1:0] prod_ff;

   logic                          res_status_ff;
   logic [bffa_pkg::ADDR_W-1:0]   res_addr_ff;
   logic [bffa_pkg::LEN_W-1:0]    res_bits_ff;
   logic                          rsp_valid_ff;
   logic                          rsp_status_ff;
   logic [bffa_pkg::ADDR_W-1:0]   rsp_addr_ff;
   logic [bffa_pkg::LEN_W-1:0]    rsp_bits_ff;

   // memories
   logic [bffa_pkg::WORD_BITS-1:0] bm_mem [bffa_pkg::WORDS];
   logic [bffa_pkg::LEN_W-1:0]     tbl_mem [bffa_pkg::MAP_BITS];
   logic [bffa_pkg::WORD_BITS-1:0] bm_rdata_ff;
   logic [bffa_pkg::LEN_W-1:0]     tbl_rdata_ff;
   logic                           bm_we;
   logic [bffa_pkg::WADDR_W-1:0]   bm_waddr;
   logic [bffa_pkg::WORD_BITS-1:0] bm_wdata;
   logic [bffa_pkg::WADDR_W-1:0]   bm_raddr;
   logic                           tbl_we;
   logic [bffa_pkg::IDX_W-1:0]     tbl_waddr;
   logic [bffa_pkg::LEN_W-1:0]     tbl_wdata;

   logic                          req_fire;
   logic [bffa_pkg::GRAN_W-1:0]   gran;
   logic [bffa_pkg::GRAN_W:0]     trial;
   logic                          trial_ge;
   logic [bffa_pkg::GRAN_W-1:0]   rem_next;
   logic                          round_up;
   logic [bffa_pkg::ADDR_W:0]     q_adj;
   logic [bffa_pkg::LEN_W-1:0]    nbits_new;
   logic [bffa_pkg::LEN_W-1:0]    zc;
   logic                          hit;
   logic [bffa_pkg::BIT_W-1:0]    hit_b;
   logic [bffa_pkg::IDX_W-1:0]    hit_pos;
   logic [bffa_pkg::IDX_W-1:0]    run_start;
   logic [bffa_pkg::LEN_W-1:0]    bit_pos;
   logic [bffa_pkg::WORD_BITS-1:0] fill_mask;
   logic [bffa_pkg::LEN_W-1:0]    hi_m1;
   logic [bffa_pkg::WADDR_W-1:0]  last_w;
   logic [bffa_pkg::LEN_W:0]      free_end;
   logic [bffa_pkg::LEN_W-1:0]    free_hi;

   assign req_fire        = req_bus.valid && req_bus.ready;
   assign req_bus.ready   = (state_ff == ST_IDLE) && !done_ff;
   assign csr_bus.ready   = 1'b1;
   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.status  = rsp_status_ff;
   assign rsp_bus.result_addr = rsp_addr_ff;
   assign rsp_bus.run_bits    = rsp_bits_ff;

   assign gran     = (bpb_ff == '0) ? bffa_pkg::GRAN_W'(1) : bpb_ff;
   assign trial    = {rem_ff, dq_ff[bffa_pkg::ADDR_W-1]};
   assign trial_ge = trial >= {1'b0, gran};
   assign rem_next = trial_ge ? bffa_pkg::GRAN_W'(trial - {1'b0, gran})
                              : bffa_pkg::GRAN_W'(trial);
   assign round_up  = {rem_ff, 1'b0} >= {1'b0, gran};
   assign q_adj     = {1'b0, dq_ff} + (bffa_pkg::ADDR_W+1)'(round_up);
   assign nbits_new = bffa_pkg::LEN_W'(q_adj) + bffa_pkg::LEN_W'(1);

   // first-fit search over one bitmap byte
   always_comb begin
      zc    = zeros_ff;
      hit   = 1'b0;
      hit_b = '0;
      for (int b = 0; b < bffa_pkg::WORD_BITS; b++) begin
         if (!hit) begin
            if (bm_rdata_ff[b]) zc = '0;
            else                zc = bffa_pkg::LEN_W'(zc + 1'b1);
            if (zc >= need_ff) begin
               hit   = 1'b1;
               hit_b = bffa_pkg::BIT_W'(b);
            end
         end
      end
   end

   assign hit_pos   = {scan_w_ff, hit_b};
   assign run_start = bffa_pkg::IDX_W'({1'b0, hit_pos} - nbits_ff);

   always_comb begin
      fill_mask = '0;
      bit_pos   = '0;
      for (int b = 0; b < bffa_pkg::WORD_BITS; b++) begin
         bit_pos      = bffa_pkg::LEN_W'({fill_w_ff, bffa_pkg::BIT_W'(b)});
         fill_mask[b] = (bit_pos >= lo_ff) && (bit_pos < hi_ff);
      end
   end

   assign hi_m1    = hi_ff - bffa_pkg::LEN_W'(1);
   assign last_w   = hi_m1[bffa_pkg::IDX_W-1:bffa_pkg::BIT_W];
   assign free_end = (bffa_pkg::LEN_W+1)'(idx_ff) + (bffa_pkg::LEN_W+1)'(tbl_rdata_ff);
   assign free_hi  = (free_end > (bffa_pkg::LEN_W+1)'(bffa_pkg::MAP_BITS))
                     ? bffa_pkg::LEN_W'(bffa_pkg::MAP_BITS) : bffa_pkg::LEN_W'(free_end);

   // memory port control
   always_comb begin
      bm_we     = 1'b0;
      bm_waddr  = fill_w_ff;
      bm_wdata  = fill_set_ff ? (bm_rdata_ff | fill_mask) : (bm_rdata_ff & ~fill_mask);
      bm_raddr  = fill_w_ff;
      tbl_we    = 1'b0;
      tbl_waddr = idx_ff;
      tbl_wdata = '0;
      case (state_ff)
         ST_CLEAR: begin
            bm_we     = 1'b1;
            bm_waddr  = clr_ff[bffa_pkg::WADDR_W-1:0];
            bm_wdata  = '0;
            tbl_we    = 1'b1;
            tbl_waddr = clr_ff;
         end
         ST_POST: bm_raddr = '0;
         ST_SCAN: begin
            bm_raddr  = bffa_pkg::WADDR_W'(scan_w_ff + 1'b1);
            tbl_we    = hit;
            tbl_waddr = run_start;
            tbl_wdata = nbits_ff;
         end
         ST_TREAD: tbl_we = (tbl_rdata_ff != '0);
         ST_FILL_WR: bm_we = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (bm_we) bm_mem[bm_waddr] <= bm_wdata;
      bm_rdata_ff <= bm_mem[bm_raddr];
   end

   always_ff @(posedge clock) begin
      if (tbl_we) tbl_mem[tbl_waddr] <= tbl_wdata;
      tbl_rdata_ff <= tbl_mem[dq_ff[bffa_pkg::IDX_W-1:0]];
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff         <= 1'b1;
         pool_bytes_ff <= bffa_pkg::SIZE_W'(65536);
         bpb_ff        <= bffa_pkg::GRAN_W'(64);
         base_ff       <= '0;
      end else if (csr_bus.valid) begin
         case (bffa_pkg::csr_index_type'(csr_bus.index))
            bffa_pkg::CSR_POOL_ENABLED:  en_ff         <= csr_bus.data[0];
            bffa_pkg::CSR_POOL_BYTES:    pool_bytes_ff <= csr_bus.data[bffa_pkg::SIZE_W-1:0];
            bffa_pkg::CSR_BYTES_PER_BIT: bpb_ff        <= csr_bus.data[bffa_pkg::GRAN_W-1:0];
            bffa_pkg::CSR_POOL_BASE:     base_ff       <= csr_bus.data;
            default: ;
         endcase
      end
   end

   // request sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (done_ff && (!rsp_valid_ff || rsp_bus.ready)) begin
            rsp_valid_ff  <= 1'b1;
            rsp_status_ff <= res_status_ff;
            rsp_addr_ff   <= res_addr_ff;
            rsp_bits_ff   <= res_bits_ff;
            done_ff       <= 1'b0;
         end else if (rsp_valid_ff && rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= bffa_pkg::IDX_W'(clr_ff + 1'b1);
               if (clr_ff == bffa_pkg::IDX_W'(bffa_pkg::MAP_BITS - 1)) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (req_fire) begin
                  cmd_ff        <= req_bus.cmd;
                  rem_ff        <= '0;
                  div_cnt_ff    <= '0;
                  res_status_ff <= bffa_pkg::STATUS_HEAP;
                  res_addr_ff   <= '0;
                  res_bits_ff   <= '0;
                  if (req_bus.cmd == bffa_pkg::CMD_ALLOC) begin
                     dq_ff <= bffa_pkg::ADDR_W'(req_bus.req_size);
                     if (!en_ff || (req_bus.req_size > pool_bytes_ff)) done_ff <= 1'b1;
                     else state_ff <= ST_DIV;
                  end else begin
                     dq_ff <= req_bus.free_addr - base_ff;
                     if (!en_ff) done_ff <= 1'b1;
                     else state_ff <= ST_DIV;
                  end
               end
            end
            ST_DIV: begin
               rem_ff     <= rem_next;
               dq_ff      <= {dq_ff[bffa_pkg::ADDR_W-2:0], trial_ge};
               div_cnt_ff <= bffa_pkg::DIV_CNT_W'(div_cnt_ff + 1'b1);
               if (div_cnt_ff == '1) state_ff <= ST_POST;
            end
            ST_POST: begin
               if (cmd_ff == bffa_pkg::CMD_ALLOC) begin
                  if (q_adj >= (bffa_pkg::ADDR_W+1)'(bffa_pkg::MAP_BITS)) begin
                     done_ff  <= 1'b1;
                     state_ff <= ST_IDLE;
                  end else begin
                     nbits_ff  <= nbits_new;
                     need_ff   <= bffa_pkg::LEN_W'(nbits_new + 1'b1);
                     zeros_ff  <= '0;
                     scan_w_ff <= '0;
                     state_ff  <= ST_SCAN;
                  end
               end else begin
                  idx_ff <= dq_ff[bffa_pkg::IDX_W-1:0];
                  if ((rem_ff != '0) ||
                      (dq_ff >= bffa_pkg::ADDR_W'(bffa_pkg::MAP_BITS))) begin
                     done_ff  <= 1'b1;
                     state_ff <= ST_IDLE;
                  end else begin
                     state_ff <= ST_TREAD;
                  end
               end
            end
            ST_TREAD: begin
               if (tbl_rdata_ff == '0) begin
                  done_ff  <= 1'b1;
                  state_ff <= ST_IDLE;
               end else begin
                  res_status_ff <= bffa_pkg::STATUS_POOL;
                  res_bits_ff   <= tbl_rdata_ff;
                  lo_ff         <= bffa_pkg::LEN_W'(idx_ff);
                  hi_ff         <= free_hi;
                  fill_w_ff     <= idx_ff[bffa_pkg::IDX_W-1:bffa_pkg::BIT_W];
                  fill_set_ff   <= 1'b0;
                  state_ff      <= ST_FILL_RD;
               end
            end
            ST_SCAN: begin
               zeros_ff  <= zc;
               scan_w_ff <= bffa_pkg::WADDR_W'(scan_w_ff + 1'b1);
               if (hit) begin
                  res_status_ff <= bffa_pkg::STATUS_POOL;
                  res_bits_ff   <= nbits_ff;
                  lo_ff         <= bffa_pkg::LEN_W'(run_start);
                  hi_ff         <= bffa_pkg::LEN_W'(hit_pos);
                  fill_w_ff     <= run_start[bffa_pkg::IDX_W-1:bffa_pkg::BIT_W];
                  fill_set_ff   <= 1'b1;
                  prod_ff       <= (bffa_pkg::IDX_W+bffa_pkg::GRAN_W)'(run_start * gran);
                  state_ff      <= ST_FILL_RD;
               end else if (scan_w_ff == bffa_pkg::WADDR_W'(bffa_pkg::WORDS - 1)) begin
                  done_ff  <= 1'b1;
                  state_ff <= ST_IDLE;
               end
            end
            ST_FILL_RD: state_ff <= ST_FILL_WR;
            ST_FILL_WR: begin
               if (fill_w_ff == last_w) begin
                  if (fill_set_ff) res_addr_ff <= base_ff + bffa_pkg::ADDR_W'(prod_ff);
                  done_ff  <= 1'b1;
                  state_ff <= ST_IDLE;
               end else begin
                  fill_w_ff <= bffa_pkg::WADDR_W'(fill_w_ff + 1'b1);
                  state_ff  <= ST_FILL_RD;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   `BFFA_ASSERT(a_req_leaves_idle, req_fire |=> (state_ff != ST_IDLE) || done_ff, "request accepted but sequencer did not start")
   `BFFA_ASSERT(a_fill_in_range, (state_ff == ST_FILL_WR) |-> (fill_w_ff <= last_w), "run update beyond its last byte")
   `BFFA_ASSERT(a_done_delivers, (done_ff && (!rsp_valid_ff || rsp_bus.ready)) |=> rsp_valid_ff && !done_ff, "finished result not moved to output")
   `BFFA_ASSERT_ALWAYS(a_no_req_in_clear, (state_ff == ST_CLEAR) |-> !req_bus.ready, "request taken during memory clear")

endmodule

[verif/bitmap_first_fit_allocator_test.sv]
// self-checking testbench for the bitmap first-fit allocator
// depends on bffa_pkg, the channel interfaces in bffa_if.sv and the allocator top level
`timescale 1ns / 1ps

module bitmap_first_fit_allocator_test;

   localparam int IDLE_LIMIT = 20000;

   typedef struct packed {
      bffa_pkg::status_type               status;
      logic [bffa_pkg::ADDR_W-1:0]        addr;
      logic [bffa_pkg::LEN_W-1:0]         bits;
   } alloc_result_type;

   logic clock;
   logic reset;

   bffa_req_if req_bus();
   bffa_rsp_if rsp_bus();
   bffa_csr_if csr_bus();

   bitmap_first_fit_allocator dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source),
      .csr_bus (csr_bus.sink)
   );

   // model state
   logic [bffa_pkg::MAP_BITS-1:0] occupied;
   logic [bffa_pkg::LEN_W-1:0]    run_len [bffa_pkg::MAP_BITS];
   logic                          pool_on;
   logic [bffa_pkg::SIZE_W-1:0]   pool_limit;
   logic [bffa_pkg::GRAN_W-1:0]   granule_bytes;
   logic [bffa_pkg::ADDR_W-1:0]   base_addr;

   alloc_result_type              pending_q [$];
   logic [bffa_pkg::ADDR_W-1:0]   live_addrs [$];
   int                            mismatches;
   int                            send_idle_pct;
   int                            recv_idle_pct;
   int                            hold_off;
   int                            quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic alloc_result_type predict_alloc(logic [63:0] size);
      alloc_result_type r;
      logic [63:0] g, nb, zeros, start;
      r = '{bffa_pkg::STATUS_HEAP, '0, '0};
      if (!pool_on || size > {32'd0, pool_limit}) return r;
      g = (granule_bytes == 0) ? 64'd1 : {43'd0, granule_bytes};
      nb = 1 + (size + size % g) / g;
      if (nb >= bffa_pkg::MAP_BITS) return r;
      zeros = 0;
      for (int j = 0; j < bffa_pkg::MAP_BITS; j++) begin
         if (occupied[j]) begin
            zeros = 0;
         end else begin
            zeros++;
            if (zeros >= nb + 1) begin
               start = j - nb;
               for (int k = 0; k < nb; k++) occupied[start + k] = 1'b1;
               run_len[start] = nb[bffa_pkg::LEN_W-1:0];
               r = '{bffa_pkg::STATUS_POOL, base_addr + start * g, nb[bffa_pkg::LEN_W-1:0]};
               return r;
            end
         end
      end
      return r;
   endfunction

   function automatic alloc_result_type predict_free(logic [63:0] addr);
      alloc_result_type r;
      logic [63:0] g, off, idx, len;
      r = '{bffa_pkg::STATUS_HEAP, '0, '0};
      if (!pool_on) return r;
      g = (granule_bytes == 0) ? 64'd1 : {43'd0, granule_bytes};
      off = addr - base_addr;
      if (off % g != 0) return r;
      idx = off / g;
      if (idx >= bffa_pkg::MAP_BITS) return r;
      if (run_len[idx] == 0) return r;
      len = run_len[idx];
      for (longint k = idx; k < idx + len && k < bffa_pkg::MAP_BITS; k++) occupied[k] = 1'b0;
      run_len[idx] = '0;
      r = '{bffa_pkg::STATUS_POOL, '0, len[bffa_pkg::LEN_W-1:0]};
      return r;
   endfunction

   task automatic send_request(bffa_pkg::cmd_type cmd, logic [31:0] size, logic [63:0] addr);
      logic taken;
      alloc_result_type r;
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.cmd       <= cmd;
      req_bus.req_size  <= size;
      req_bus.free_addr <= addr;
      do begin
         @(negedge clock);
         taken = req_bus.ready;
         @(posedge clock);
      end while (!taken);
      if (cmd == bffa_pkg::CMD_ALLOC) begin
         r = predict_alloc({32'd0, size});
         if (r.status == bffa_pkg::STATUS_POOL) live_addrs.push_back(r.addr);
      end else begin
         r = predict_free(addr);
      end
      pending_q.push_back(r);
   endtask

   task automatic alloc_bytes(logic [31:0] size);
      send_request(bffa_pkg::CMD_ALLOC, size, {$urandom, $urandom});
   endtask

   task automatic free_addr(logic [63:0] addr);
      send_request(bffa_pkg::CMD_FREE, $urandom, addr);
   endtask

   task automatic free_oldest();
      if (live_addrs.size() > 0) free_addr(live_addrs.pop_front());
   endtask

   task automatic write_reg(bffa_pkg::csr_index_type idx, logic [63:0] data);
      logic taken;
      req_bus.valid <= 1'b0;
      wait (pending_q.size() == 0);
      repeat (420) @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      do begin
         @(negedge clock);
         taken = csr_bus.ready;
         @(posedge clock);
      end while (!taken);
      csr_bus.valid <= 1'b0;
      case (idx)
         bffa_pkg::CSR_POOL_ENABLED:  pool_on       = data[0];
         bffa_pkg::CSR_POOL_BYTES:    pool_limit    = data[31:0];
         bffa_pkg::CSR_BYTES_PER_BIT: granule_bytes = data[bffa_pkg::GRAN_W-1:0];
         bffa_pkg::CSR_POOL_BASE:     base_addr     = data;
         default: ;
      endcase
   endtask

   // response checker
   always @(negedge clock) begin
      alloc_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response at %0t", $realtime);
         end else begin
            want = pending_q.pop_front();
            if (rsp_bus.status !== want.status || rsp_bus.result_addr !== want.addr ||
                rsp_bus.run_bits !== want.bits) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("response %0t: expected %0d/%h/%0d got %0d/%h/%0d", $realtime,
                           want.status, want.addr, want.bits, rsp_bus.status,
                           rsp_bus.result_addr, rsp_bus.run_bits);
            end
         end
      end
   end

   // response back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // watchdog
   always @(negedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("bitmap_first_fit_allocator: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic test_alloc_sizes();
      alloc_bytes(0);
      alloc_bytes(63);
      alloc_bytes(64);
      alloc_bytes(65472);
      alloc_bytes(65536);
      alloc_bytes(65537);
      alloc_bytes(32'hFFFF_FFFF);
   endtask

   task automatic test_free_cases();
      logic [63:0] a;
      a = live_addrs.pop_front();
      free_addr(a);
      free_addr(a);
      free_addr(a + 1);
      free_addr(64'd64 * bffa_pkg::MAP_BITS);
      free_addr(64'hFFFF_FFFF_FFFF_FFFF);
      free_oldest();
   endtask

   task automatic test_map_full();
      repeat (17) alloc_bytes(4000);
      repeat (17) free_oldest();
   endtask

   task automatic test_registers();
      write_reg(bffa_pkg::CSR_BYTES_PER_BIT, 0);
      alloc_bytes(5);
      free_oldest();
      write_reg(bffa_pkg::CSR_POOL_ENABLED, 0);
      alloc_bytes(8);
      free_addr(0);
      write_reg(bffa_pkg::CSR_POOL_ENABLED, 1);
      write_reg(bffa_pkg::CSR_BYTES_PER_BIT, 64);
      write_reg(bffa_pkg::CSR_POOL_BYTES, 0);
      alloc_bytes(0);
      alloc_bytes(1);
      write_reg(bffa_pkg::CSR_POOL_BYTES, 65536);
      write_reg(bffa_pkg::CSR_POOL_BASE, 64'hFFFF_FFFF_FFFF_FFF0);
      alloc_bytes(10);
      alloc_bytes(10);
      free_oldest();
      free_oldest();
   endtask

   task automatic random_traffic(int count, int max_size);
      int pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 55) alloc_bytes($urandom_range(max_size));
         else if (pick < 88 && live_addrs.size() > 0)
            free_addr(live_addrs[$urandom_range(live_addrs.size() - 1)]);
         else if (pick < 94) alloc_bytes($urandom);
         else free_addr({$urandom, $urandom});
      end
   endtask

   task automatic test_back_pressure();
      hold_off <= 3000;
      random_traffic(12, 600);
      req_bus.valid <= 1'b0;
      wait (pending_q.size() == 0);
      random_traffic(10, 600);
   endtask

   initial begin
      mismatches = 0;
      hold_off = 0;
      quiet_cycles = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      occupied = '0;
      foreach (run_len[i]) run_len[i] = '0;
      pool_on = 1'b1;
      pool_limit = 65536;
      granule_bytes = 64;
      base_addr = '0;
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.cmd <= bffa_pkg::CMD_ALLOC;
      req_bus.req_size <= '0;
      req_bus.free_addr <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.index <= bffa_pkg::CSR_POOL_ENABLED;
      csr_bus.data <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_alloc_sizes();
      test_free_cases();
      test_map_full();
      test_registers();

      send_idle_pct = 38;
      recv_idle_pct = 87;
      write_reg(bffa_pkg::CSR_POOL_BASE, {$urandom, $urandom});
      random_traffic(180, 3000);
      test_back_pressure();

      send_idle_pct = 87;
      recv_idle_pct = 38;
      write_reg(bffa_pkg::CSR_BYTES_PER_BIT, 1);
      write_reg(bffa_pkg::CSR_POOL_BYTES, 2000);
      write_reg(bffa_pkg::CSR_POOL_BASE, 64'hFFFF_FFFF_FFFF_FE00);
      random_traffic(170, 300);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_reg(bffa_pkg::CSR_BYTES_PER_BIT, 1048576);
      write_reg(bffa_pkg::CSR_POOL_BYTES, 32'hFFFF_FFFF);
      write_reg(bffa_pkg::CSR_POOL_BASE, {$urandom, $urandom});
      random_traffic(80, 200_000_000);
      write_reg(bffa_pkg::CSR_BYTES_PER_BIT, 48);
      write_reg(bffa_pkg::CSR_POOL_BYTES, 40000);
      random_traffic(80, 2500);

      req_bus.valid <= 1'b0;
      wait (pending_q.size() == 0);
      repeat (500) @(posedge clock);
      if (mismatches == 0) begin
         $display("bitmap_first_fit_allocator: match");
      end else begin
         $display("bitmap_first_fit_allocator: mismatch");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+sv
sv/bffa_pkg.sv
sv/bffa_if.sv
sv/bitmap_first_fit_allocator.sv
verif/bitmap_first_fit_allocator_test.sv
